[rtl/core/rgbp_pkg.sv]
// rgbp_pkg: shared types and constants of the 24-to-512 bit packer
// no dependencies; used by the interfaces and by every module of the core

package rgbp_pkg;

  localparam int WORD_W   = 512;
  localparam int ITEM_W   = 24;
  localparam int LANE_W   = 64;
  localparam int FILL_W   = 9;
  localparam int HDR_W    = 48;
  localparam int LEN_W    = 16;
  localparam int HOUT_W   = 64;
  localparam int WIDE_W   = WORD_W + ITEM_W;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  // one input request
  typedef struct packed {
    logic [ITEM_W-1:0] pixel_bits;
    logic              burst_end;
    logic [HDR_W-1:0]  header_low;
    logic [LEN_W-1:0]  padded_length;
  } pix_in_t;

  // one result request
  typedef struct packed {
    logic [LANE_W-1:0] lane0;
    logic [LANE_W-1:0] lane1;
    logic [LANE_W-1:0] lane2;
    logic [LANE_W-1:0] lane3;
    logic [LANE_W-1:0] lane4;
    logic [LANE_W-1:0] lane5;
    logic [LANE_W-1:0] lane6;
    logic [LANE_W-1:0] lane7;
    logic              word_valid;
    logic              header_valid;
    logic [HOUT_W-1:0] header_out;
  } word_out_t;

  // classified operation handed from the front to the back
  typedef struct packed {
    logic [ITEM_W-1:0] pixel_bits;
    logic [FILL_W-1:0] pos;
    logic              emit;
    logic              hdr_valid;
    logic [HOUT_W-1:0] header_out;
  } pack_op_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/core/rgbp_if.sv]
// rgbp_if: valid/ready channel interfaces for the packer input and result
// depends on rgbp_pkg for the payload types

interface rgbp_in_if import rgbp_pkg::*; ();
  logic    valid;
  logic    ready;
  pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rgbp_out_if import rgbp_pkg::*; ();
  logic      valid;
  logic      ready;
  word_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/rgb24_to_512bit_packer_core.sv]
// rgb24_to_512bit_packer_core: top level of the 24-to-512 bit packer
// depends on rgbp_pkg, rgbp_if, rgbp_front, rgbp_queue and rgbp_back
//
// usage:
// - in_if carries one pixel request per handshake (24 data bits, burst end
//   flag, low header bits and padded burst length); out_if carries one packed
//   512-bit word as eight 64-bit lanes plus the optional control header
// - a request is taken at a rising edge with valid and ready both high
// - the front accepts one request per cycle while the queue is not full
//   and tracks the fill count, a two-entry queue decouples it from the
//   back, which packs bits into the store and loads the output register
// - throughput: one request per cycle, sustained while the receiver keeps up
// - a request that completes a word reaches out_if through the queue write,
//   then the output register load
// - a receiver stall holds the output word; the back still drains requests
//   that only fill the store, and stops at the next one that completes a
//   word, so in_if.ready drops once the two queue entries are taken
// - header is sent only when a burst's last request ends exactly on a word
//   boundary; otherwise header_valid and header_out are zero
// - synchronous reset clears the fill count, the store, the queue and the
//   output valid; it needs no clearing pass

module rgb24_to_512bit_packer_core import rgbp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  rgbp_in_if.sink     in_if,
  rgbp_out_if.source  out_if
);

  // front to queue
  logic              push;
  pack_op_t          push_op;
  logic [FILL_W-1:0] fill_bits;

  // queue to back
  logic              pop;
  pack_op_t          head_op;
  q_stat_t           q_stat;

  // classify request and keep fill count
  rgbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_data   (in_if.data),
    .in_ready  (in_if.ready),
    .q_stat    (q_stat),
    .push      (push),
    .push_op   (push_op),
    .fill_bits (fill_bits)
  );

  // short decoupling queue
  rgbp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  // packing store and output register
  rgbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_op   (head_op),
    .pop       (pop),
    .out_valid (out_if.valid),
    .out_data  (out_if.data),
    .out_ready (out_if.ready)
  );

  // fill count moves in whole bytes since both 24 and 512 do
  a_fill_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    fill_bits[2:0] == 3'd0)
    else $error("fill count not byte aligned");

  // a header request closes a word exactly, leaving nothing carried
  a_hdr_clears_fill: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_op.hdr_valid |=> fill_bits == '0)
    else $error("fill count not zero after header request");

  // no header value leaks out without header_valid
  a_hdr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.data.header_valid |-> out_if.data.header_out == '0)
    else $error("header_out set without header_valid");

  // the back never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

endmodule

[rtl/core/rgbp_front.sv]
// rgbp_front: accepts input requests, tracks the fill count, classifies
// each request (word complete, header due) and builds the header value
// depends on rgbp_pkg

module rgbp_front import rgbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pix_in_t           in_data,
  output logic              in_ready,
  input  q_stat_t           q_stat,
  output logic              push,
  output pack_op_t          push_op,
  output logic [FILL_W-1:0] fill_bits
);

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W:0]   end_pos;
  logic [LEN_W-1:0]  quarter;
  logic [LEN_W-1:0]  len_unpad;
  logic              exact;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign end_pos = {1'b0, fill_r} + (FILL_W+1)'(ITEM_W);
  assign exact   = (end_pos == (FILL_W+1)'(WORD_W));

  // three quarters of the length as shift and add
  assign quarter   = in_data.padded_length >> 2;
  assign len_unpad = (quarter << 1) + quarter;

  always_comb begin
    push_op.pixel_bits = in_data.pixel_bits;
    push_op.pos        = fill_r;
    push_op.emit       = end_pos[FILL_W];
    push_op.hdr_valid  = exact && in_data.burst_end;
    push_op.header_out = '0;
    if (exact && in_data.burst_end) begin
      push_op.header_out = {len_unpad, in_data.header_low};
    end
  end

  // past the word boundary the low bits are the carried count
  assign fill_nxt  = end_pos[FILL_W-1:0];
  assign fill_bits = fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (push) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

[rtl/core/rgbp_queue.sv]
// rgbp_queue: two-entry queue of classified operations between front and back
// depends on rgbp_pkg

module rgbp_queue import rgbp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  pack_op_t push_op,
  input  logic     pop,
  output pack_op_t head_op,
  output q_stat_t  stat
);

  pack_op_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign head_op    = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[rtl/core/rgbp_back.sv]
// rgbp_back: places pixel bits into the packing store and loads the
// output register when a word completes
// depends on rgbp_pkg

module rgbp_back import rgbp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  pack_op_t  head_op,
  output logic      pop,
  output logic      out_valid,
  output word_out_t out_data,
  input  logic      out_ready
);

  logic [WORD_W-1:0] store_r;
  logic [WIDE_W-1:0] placed;
  logic [WIDE_W-1:0] wide;
  logic              out_valid_r;
  word_out_t         out_data_r;
  logic              out_free;

  // bits past the word top land in the carry slice of the wide vector
  assign placed = {{WORD_W{1'b0}}, head_op.pixel_bits} << head_op.pos;
  assign wide   = {{ITEM_W{1'b0}}, store_r} | placed;

  assign out_free = !out_valid_r || out_ready;
  assign pop      = !q_stat.empty && (!head_op.emit || out_free);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
    end else if (pop) begin
      if (head_op.emit) begin
        store_r <= {{(WORD_W-ITEM_W){1'b0}}, wide[WIDE_W-1:WORD_W]};
      end else begin
        store_r <= wide[WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && head_op.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.emit) begin
      out_data_r.lane0        <= wide[0*LANE_W +: LANE_W];
      out_data_r.lane1        <= wide[1*LANE_W +: LANE_W];
      out_data_r.lane2        <= wide[2*LANE_W +: LANE_W];
      out_data_r.lane3        <= wide[3*LANE_W +: LANE_W];
      out_data_r.lane4        <= wide[4*LANE_W +: LANE_W];
      out_data_r.lane5        <= wide[5*LANE_W +: LANE_W];
      out_data_r.lane6        <= wide[6*LANE_W +: LANE_W];
      out_data_r.lane7        <= wide[7*LANE_W +: LANE_W];
      out_data_r.word_valid   <= 1'b1;
      out_data_r.header_valid <= head_op.hdr_valid;
      out_data_r.header_out   <= head_op.header_out;
    end
  end

endmodule
